// ===== hw/rtl/ball_reflect_and_advance_macros.svh =====
// Assertion macros for the ball reflect-and-advance block.
`ifndef BALL_REFLECT_AND_ADVANCE_MACROS_SVH
`define BALL_REFLECT_AND_ADVANCE_MACROS_SVH

// Same-cycle implication.
`define BRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bra assertion failed");

// Next-cycle implication.
`define BRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bra assertion failed");

`endif

// ===== hw/rtl/bra_pkg.sv =====
package bra_pkg;

  localparam int POS_W     = 24;
  localparam int DIR_W     = 16;
  localparam int DIR_FRAC  = DIR_W - 2;
  localparam int ANG_W     = 16;
  localparam int SPEED_W   = 16;
  localparam int CORDIC_W  = 34;
  localparam int CORDIC_FRAC = 30;
  localparam int CORDIC_STEPS = 16;
  localparam int MUL_B_W   = SPEED_W + 2;
  localparam int MUL_P_W   = DIR_W + MUL_B_W + 2;
  localparam int WIDE_W    = 48;

  localparam logic [SPEED_W-1:0]  SPEED_RESET = SPEED_W'(256);
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);
  localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1 <<< DIR_FRAC);

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic [ANG_W-1:0]        ang_t;
  typedef logic [SPEED_W-1:0]      speed_t;

  function automatic logic signed [16:0] atan_lut(input logic [3:0] idx);
    logic signed [16:0] v;
    case (idx)
      4'd0:  v = 17'sd8192;
      4'd1:  v = 17'sd4836;
      4'd2:  v = 17'sd2555;
      4'd3:  v = 17'sd1297;
      4'd4:  v = 17'sd651;
      4'd5:  v = 17'sd326;
      4'd6:  v = 17'sd163;
      4'd7:  v = 17'sd81;
      4'd8:  v = 17'sd41;
      4'd9:  v = 17'sd20;
      4'd10: v = 17'sd10;
      4'd11: v = 17'sd5;
      4'd12: v = 17'sd3;
      4'd13: v = 17'sd1;
      4'd14: v = 17'sd1;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic dir_t clamp_unit(input logic signed [WIDE_W-1:0] v);
    dir_t r;
    if (v > WIDE_W'(DIR_ONE)) begin
      r = DIR_ONE;
    end else if (v < -WIDE_W'(DIR_ONE)) begin
      r = -DIR_ONE;
    end else begin
      r = v[DIR_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bra_if.sv =====
interface bra_in_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic                 hit_wall;
  bra_pkg::ang_t        wall_angle;
  bra_pkg::pos_t        launch_x;
  bra_pkg::pos_t        launch_y;
  bra_pkg::ang_t        launch_angle;
  modport source (output valid, op, hit_wall, wall_angle, launch_x, launch_y, launch_angle,
                  input ready);
  modport sink (input valid, op, hit_wall, wall_angle, launch_x, launch_y, launch_angle,
                output ready);
endinterface

interface bra_out_if;
  logic          valid;
  logic          ready;
  bra_pkg::pos_t pos_x;
  bra_pkg::pos_t pos_y;
  bra_pkg::dir_t dir_x;
  bra_pkg::dir_t dir_y;
  logic          bounced;
  logic          clamped;
  modport source (output valid, pos_x, pos_y, dir_x, dir_y, bounced, clamped, input ready);
  modport sink (input valid, pos_x, pos_y, dir_x, dir_y, bounced, clamped, output ready);
endinterface

interface bra_cfg_if;
  logic            valid;
  logic            ready;
  bra_pkg::speed_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/ball_reflect_and_advance.sv =====
// Ball reflect-and-advance engine. One beat in gives one beat out, one item at a time.
// A launch runs 16 CORDIC iterations for cosine and sine, then loads the output register.
// A tick without a wall hit computes two products of speed and direction through the
// bit-serial multiplier, one multiplier bit per cycle, each after an operand load. A tick
// with a wall hit adds the CORDIC pass for the wall normal and four more products.
// Input is taken again the cycle after the result has moved to the output register; a
// result still waiting in the output register holds the engine until it is taken.
`include "ball_reflect_and_advance_macros.svh"

module ball_reflect_and_advance (
  input logic     clk,
  input logic     rst_n,
  bra_in_if.sink  in_ch,
  bra_out_if.source out_ch,
  bra_cfg_if.sink cfg_ch
);
  import bra_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CORDIC, S_LOAD, S_MUL, S_OUT} state_t;

  state_t state_r;
  logic   op_r, bounced_r, clamped_r;
  logic [2:0] mstep_r;
  logic [4:0] cnt_r;
  logic [1:0] quad_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r;
  logic signed [16:0] cz_r;
  dir_t nx_r, ny_r, hx_r, hy_r;
  logic signed [MUL_B_W-1:0] d2_r, mb_r;
  logic signed [MUL_P_W:0] dot_r;
  logic signed [MUL_P_W-1:0] acc_r, ma_r;
  pos_t px_r, py_r;
  speed_t speed_r;
  logic out_valid_r, out_bounced_r, out_clamped_r;
  pos_t out_px_r, out_py_r;
  dir_t out_dx_r, out_dy_r;

  logic signed [CORDIC_W-1:0] xs, ys, cx_nxt, cy_nxt, cc, ss;
  logic signed [16:0] cz_nxt;
  logic signed [CORDIC_W-1:0] cc_rnd, ss_rnd;
  dir_t c_val, s_val;
  dir_t a_sel;
  logic signed [MUL_B_W-1:0] b_sel;
  logic signed [MUL_P_W-1:0] acc_nxt, p_rnd;
  logic signed [MUL_P_W:0] dsum, dsum_rnd;
  logic signed [WIDE_W-1:0] hnew, pnew;
  logic pos_over, pos_under;
  pos_t pos_sat;
  logic [ANG_W-1:0] ang_sel;
  logic in_fire;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.pos_x   = out_px_r;
  assign out_ch.pos_y   = out_py_r;
  assign out_ch.dir_x   = out_dx_r;
  assign out_ch.dir_y   = out_dy_r;
  assign out_ch.bounced = out_bounced_r;
  assign out_ch.clamped = out_clamped_r;

  always_comb begin
    xs = cx_r >>> cnt_r[3:0];
    ys = cy_r >>> cnt_r[3:0];
    if (!cz_r[16]) begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - atan_lut(cnt_r[3:0]);
    end else begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + atan_lut(cnt_r[3:0]);
    end
    case (quad_r)
      2'd1:    begin cc = -cy_nxt; ss = cx_nxt;  end
      2'd2:    begin cc = -cx_nxt; ss = -cy_nxt; end
      2'd3:    begin cc = cy_nxt;  ss = -cx_nxt; end
      default: begin cc = cx_nxt;  ss = cy_nxt;  end
    endcase
    cc_rnd = (cc + CORDIC_W'(34'sd1 <<< (CORDIC_FRAC - DIR_FRAC - 1)))
             >>> (CORDIC_FRAC - DIR_FRAC);
    ss_rnd = (ss + CORDIC_W'(34'sd1 <<< (CORDIC_FRAC - DIR_FRAC - 1)))
             >>> (CORDIC_FRAC - DIR_FRAC);
    c_val = clamp_unit(WIDE_W'(cc_rnd));
    s_val = clamp_unit(WIDE_W'(ss_rnd));

    case (mstep_r)
      3'd0:    begin a_sel = hx_r; b_sel = MUL_B_W'(nx_r); end
      3'd1:    begin a_sel = hy_r; b_sel = MUL_B_W'(ny_r); end
      3'd2:    begin a_sel = nx_r; b_sel = d2_r; end
      3'd3:    begin a_sel = ny_r; b_sel = d2_r; end
      3'd4:    begin a_sel = hx_r; b_sel = $signed({2'b00, speed_r}); end
      default: begin a_sel = hy_r; b_sel = $signed({2'b00, speed_r}); end
    endcase

    if (mb_r[0]) begin
      acc_nxt = (cnt_r == 5'(MUL_B_W - 1)) ? acc_r - ma_r : acc_r + ma_r;
    end else begin
      acc_nxt = acc_r;
    end
    p_rnd    = (acc_nxt + MUL_P_W'(1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
    dsum     = dot_r + (MUL_P_W + 1)'(acc_nxt);
    dsum_rnd = (dsum + (MUL_P_W + 1)'(1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
    hnew     = (mstep_r == 3'd2) ? WIDE_W'(hx_r) - WIDE_W'(p_rnd)
                                 : WIDE_W'(hy_r) - WIDE_W'(p_rnd);
    pnew     = (mstep_r == 3'd4) ? WIDE_W'(px_r) + WIDE_W'(p_rnd)
                                 : WIDE_W'(py_r) + WIDE_W'(p_rnd);
    pos_over  = pnew > $signed(WIDE_W'({1'b0, {(POS_W - 1){1'b1}}}));
    pos_under = pnew < -$signed(WIDE_W'({1'b1, {(POS_W - 1){1'b0}}}));
    if (pos_over) begin
      pos_sat = {1'b0, {(POS_W - 1){1'b1}}};
    end else if (pos_under) begin
      pos_sat = {1'b1, {(POS_W - 1){1'b0}}};
    end else begin
      pos_sat = pnew[POS_W-1:0];
    end
    ang_sel = in_ch.op ? in_ch.launch_angle : in_ch.wall_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      speed_r     <= SPEED_RESET;
      px_r        <= '0;
      py_r        <= '0;
      hx_r        <= DIR_ONE;
      hy_r        <= '0;
      cnt_r       <= '0;
      mstep_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        speed_r <= cfg_ch.data;
      end
      if (out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r      <= in_ch.op;
            bounced_r <= 1'b0;
            clamped_r <= 1'b0;
            cx_r      <= CORDIC_GAIN;
            cy_r      <= '0;
            cz_r      <= {3'b000, ang_sel[13:0]};
            quad_r    <= ang_sel[15:14];
            cnt_r     <= '0;
            mstep_r   <= 3'd4;
            if (in_ch.op) begin
              px_r    <= in_ch.launch_x;
              py_r    <= in_ch.launch_y;
              state_r <= S_CORDIC;
            end else if (in_ch.hit_wall) begin
              mstep_r <= 3'd0;
              state_r <= S_CORDIC;
            end else begin
              state_r <= S_LOAD;
            end
          end
        end
        S_CORDIC: begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          cz_r  <= cz_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            if (op_r) begin
              hx_r    <= c_val;
              hy_r    <= s_val;
              state_r <= S_OUT;
            end else begin
              nx_r    <= -s_val;
              ny_r    <= c_val;
              state_r <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          ma_r    <= MUL_P_W'(a_sel);
          mb_r    <= b_sel;
          acc_r   <= '0;
          cnt_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r <= acc_nxt;
          ma_r  <= ma_r <<< 1;
          mb_r  <= mb_r >>> 1;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(MUL_B_W - 1)) begin
            mstep_r <= mstep_r + 3'd1;
            state_r <= S_LOAD;
            case (mstep_r)
              3'd0: dot_r <= (MUL_P_W + 1)'(acc_nxt);
              3'd1: d2_r  <= MUL_B_W'(dsum_rnd <<< 1);
              3'd2: hx_r  <= clamp_unit(hnew);
              3'd3: begin
                hy_r      <= clamp_unit(hnew);
                bounced_r <= 1'b1;
              end
              3'd4: begin
                px_r <= pos_sat;
                if (pos_over || pos_under) begin
                  clamped_r <= 1'b1;
                end
              end
              default: begin
                py_r <= pos_sat;
                if (pos_over || pos_under) begin
                  clamped_r <= 1'b1;
                end
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_px_r      <= px_r;
            out_py_r      <= py_r;
            out_dx_r      <= hx_r;
            out_dy_r      <= hy_r;
            out_bounced_r <= bounced_r;
            out_clamped_r <= clamped_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `BRA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready)
  `BRA_ASSERT_NOW(a_mul_count, state_r == S_MUL, cnt_r < 5'(MUL_B_W))
  `BRA_ASSERT_NOW(a_dir_x_unit, out_valid_r, out_dx_r <= DIR_ONE && out_dx_r >= -DIR_ONE)
  `BRA_ASSERT_NOW(a_launch_flags, out_valid_r && op_r && state_r == S_IDLE,
                  !out_bounced_r && !out_clamped_r)

endmodule
